// ===== sv/pfs_pkg.sv =====
`default_nettype none

package pfs_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_FIELD_MODE_ADDR = 3'd0;

  typedef enum logic {
    MODE_BYTE   = 1'b0,
    MODE_NIBBLE = 1'b1
  } field_mode_e;

  typedef struct packed {
    field_mode_e field_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/pfs_apb_regs.sv =====
`default_nettype none

module pfs_apb_regs
  import pfs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  field_mode_e field_mode_q, field_mode_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    field_mode_d = field_mode_q;
    if (wr_en && (paddr == REG_FIELD_MODE_ADDR)) begin
      field_mode_d = field_mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mode_q <= MODE_BYTE;
    end else begin
      field_mode_q <= field_mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      REG_FIELD_MODE_ADDR: prdata[0] = field_mode_q;
      default:             prdata    = '0;
    endcase
  end

  assign cfg_o.field_mode = field_mode_q;

endmodule

`default_nettype wire

// ===== sv/pfs_rank_sort.sv =====
`default_nettype none

module pfs_rank_sort #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned FIELD_W   = 8
) (
  input  wire logic [WORD_BITS-1:0] word_i,
  output logic      [WORD_BITS-1:0] sorted_o
);

  localparam int unsigned N      = WORD_BITS / FIELD_W;
  localparam int unsigned RANK_W = (N > 1) ? $clog2(N) : 1;

  logic [FIELD_W-1:0] fld   [N];
  logic [N-1:0]       below [N];
  logic [RANK_W-1:0]  rank  [N];
  logic [FIELD_W-1:0] slot  [N];

  // Each field's rank is the number of fields that must precede it; ties
  // are broken by position, so the ranks form a permutation.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      fld[i] = word_i[i*FIELD_W +: FIELD_W];
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        below[i][j] = (fld[j] < fld[i]) || ((fld[j] == fld[i]) && (j < i));
      end
      rank[i] = RANK_W'($countones(below[i]));
    end
  end

  always_comb begin
    for (int p = 0; p < N; p++) begin
      slot[p] = '0;
      for (int i = 0; i < N; i++) begin
        if (rank[i] == RANK_W'(p)) begin
          slot[p] = slot[p] | fld[i];
        end
      end
    end
    sorted_o = '0;
    for (int p = 0; p < N; p++) begin
      sorted_o[p*FIELD_W +: FIELD_W] = slot[p];
    end
  end

endmodule

`default_nettype wire

// ===== sv/packed_field_sort_core.sv =====
// Channel    | Direction | Payload
// s_axis     | in        | tdata: word_in (WORD_BITS bits), zero padded to bytes
// m_axis     | out       | tdata: sorted_word (WORD_BITS bits), zero padded to bytes
// APB        | in/out    | field_mode register at byte address 0
//
// A word passes one input register, then the rank sort between it and the
// result register. One transfer per cycle is sustained while the output
// is not stalled. A stalled output holds the result register, and the
// input register still takes a word while it is empty. Reset clears the
// valid flags and sets field_mode to byte mode.
`default_nettype none

module packed_field_sort_core
  import pfs_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0: word_in.
  input  wire logic [((WORD_BITS + 7) / 8)*8-1:0]  s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // Fields from bit 0: sorted_word.
  output logic      [((WORD_BITS + 7) / 8)*8-1:0]  m_axis_tdata_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [PADDR_W-1:0]                  paddr,
  input  wire logic [PDATA_W-1:0]                  pwdata,
  output logic      [PDATA_W-1:0]                  prdata,
  output logic                                     pready
);

  localparam int unsigned DATA_W = ((WORD_BITS + 7) / 8) * 8;

  cfg_t                 cfg;
  logic                 in_valid_q, in_valid_d;
  logic [WORD_BITS-1:0] word_q;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] res_q, res_d;
  logic [WORD_BITS-1:0] byte_sorted;
  logic [WORD_BITS-1:0] nibble_sorted;
  logic                 advance;
  logic                 in_xfer;

  pfs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfs_rank_sort #(
    .WORD_BITS (WORD_BITS),
    .FIELD_W   (8)
  ) u_byte_sort (
    .word_i   (word_q),
    .sorted_o (byte_sorted)
  );

  pfs_rank_sort #(
    .WORD_BITS (WORD_BITS),
    .FIELD_W   (4)
  ) u_nibble_sort (
    .word_i   (word_q),
    .sorted_o (nibble_sorted)
  );

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      res_d       = (cfg.field_mode == MODE_NIBBLE) ? nibble_sorted : byte_sorted;
    end
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= s_axis_tdata_i[WORD_BITS-1:0];
    end
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'(res_q);

endmodule

`default_nettype wire
